// ===== rtl/core/integer_alu_with_flags_defines.svh =====
// ----------------------------------------------------------------------------
// integer alu with flags: assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef INTEGER_ALU_WITH_FLAGS_DEFINES_SVH
`define INTEGER_ALU_WITH_FLAGS_DEFINES_SVH

`ifndef SYNTHESIS
`define IAF_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("iaf check failed");
`define IAF_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("iaf check failed");
`else
`define IAF_ASSERT_IMP(name, ante, cons)
`define IAF_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== rtl/core/iaf_pkg.sv =====
// ----------------------------------------------------------------------------
// iaf_pkg
// types, opcodes and flag helpers for the integer alu with flags
// ----------------------------------------------------------------------------
package iaf_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned FlagW  = 5;
  localparam int unsigned CmdW   = 6;
  localparam int unsigned ImmW   = 6;
  localparam int unsigned PredW  = 2;
  localparam int unsigned IterW  = 6;
  localparam int unsigned CountW = 7;

  localparam int unsigned FlZ = 0;
  localparam int unsigned FlN = 1;
  localparam int unsigned FlC = 2;
  localparam int unsigned FlV = 3;
  localparam int unsigned FlP = 4;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 6'd0,  CMD_ADDI   = 6'd1,  CMD_SUB    = 6'd2,  CMD_SUBI   = 6'd3,
    CMD_MUL    = 6'd4,  CMD_MULH   = 6'd5,  CMD_DIV    = 6'd6,  CMD_REM    = 6'd7,
    CMD_NEG    = 6'd8,  CMD_ABS    = 6'd9,  CMD_AND    = 6'd10, CMD_ANDI   = 6'd11,
    CMD_OR     = 6'd12, CMD_ORI    = 6'd13, CMD_XOR    = 6'd14, CMD_NOT    = 6'd15,
    CMD_SHL    = 6'd16, CMD_SHR    = 6'd17, CMD_SAR    = 6'd18, CMD_ROL    = 6'd19,
    CMD_ROR    = 6'd20, CMD_CLZ    = 6'd21, CMD_CTZ    = 6'd22, CMD_POPC   = 6'd23,
    CMD_BEXT   = 6'd24, CMD_BDEP   = 6'd25, CMD_RDFL   = 6'd26, CMD_WRFL   = 6'd27,
    CMD_CMP    = 6'd28, CMD_CMPI   = 6'd29, CMD_TST    = 6'd30, CMD_TSTI   = 6'd31,
    CMD_SEQ    = 6'd32, CMD_SNE    = 6'd33, CMD_SLT    = 6'd34, CMD_SLTU   = 6'd35,
    CMD_MOV    = 6'd36, CMD_MOVZ   = 6'd37, CMD_MOVNZ  = 6'd38, CMD_MOVC   = 6'd39,
    CMD_MOVN   = 6'd40, CMD_SEL    = 6'd41, CMD_ZEXT32 = 6'd42, CMD_SEXT32 = 6'd43,
    CMD_SEXT16 = 6'd44, CMD_SEXT8  = 6'd45
  } cmd_t;

  typedef enum logic [1:0] {
    PRED_ALWAYS = 2'd0,
    PRED_ZSET   = 2'd1,
    PRED_ZCLR   = 2'd2,
    PRED_CSET   = 2'd3
  } pred_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DNA,
    S_DNB,
    S_DIV,
    S_BITS,
    S_EXEC
  } state_t;

  function automatic logic [FlagW-1:0] arith_flags(
    input logic [DataW-1:0] r,
    input logic [DataW-1:0] x,
    input logic [DataW-1:0] y,
    input logic             sub,
    input logic             carry
  );
    logic [FlagW-1:0] f;
    f      = '0;
    f[FlZ] = (r == '0);
    f[FlN] = r[DataW-1];
    f[FlC] = sub ? ~carry : carry;
    f[FlV] = sub ? ((x[DataW-1] ^ y[DataW-1]) & (x[DataW-1] ^ r[DataW-1]))
                 : (~(x[DataW-1] ^ y[DataW-1]) & (x[DataW-1] ^ r[DataW-1]));
    f[FlP] = ~(^r[7:0]);
    return f;
  endfunction

endpackage

// ===== rtl/core/iaf_if.sv =====
// ----------------------------------------------------------------------------
// iaf channel interfaces
// valid/ready channels for operations in and results out
// ----------------------------------------------------------------------------
interface iaf_in_if import iaf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CmdW-1:0]  command;
  logic [DataW-1:0] operand_a;
  logic [DataW-1:0] operand_b;
  logic [ImmW-1:0]  imm6;
  logic [PredW-1:0] pred;

  modport source (output valid, command, operand_a, operand_b, imm6, pred, input ready);
  modport sink   (input valid, command, operand_a, operand_b, imm6, pred, output ready);
endinterface

interface iaf_out_if import iaf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] result;
  logic             write_enable;
  logic             arith_trap;
  logic [FlagW-1:0] flags_out;

  modport source (output valid, result, write_enable, arith_trap, flags_out, input ready);
  modport sink   (input valid, result, write_enable, arith_trap, flags_out, output ready);
endinterface

// ===== rtl/core/integer_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// integer_alu_with_flags
// 64-bit integer execute stage with stored z/n/c/v/p flags, built around
// one shared 64-bit adder under a small sequencer
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  in_ch    in   command, operand_a, operand_b, imm6, pred
//  out_ch   out  result, write_enable, arith_trap, flags_out
//
//  single-step operations go from accept through the exec state to the output register
//  mul, mulh, clz, ctz and popc first make 64 passes of the adder or bit scan
//  div and rem with a nonzero divisor first make two magnitude passes plus 64 restoring steps
//  one transaction at a time; a new one is taken while the last result waits
//  reset clears the flags and drops out valid
// ----------------------------------------------------------------------------
`include "integer_alu_with_flags_defines.svh"

module integer_alu_with_flags import iaf_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  iaf_in_if.sink  in_ch,
  iaf_out_if.source out_ch
);

  state_t           state_r, state_nxt;
  logic [CmdW-1:0]  cmd_r, cmd_nxt;
  logic [DataW-1:0] a_r, a_nxt;
  logic [DataW-1:0] b_r, b_nxt;
  logic [ImmW-1:0]  imm_r, imm_nxt;
  logic             pok_r, pok_nxt;
  logic [DataW-1:0] acc_hi_r, acc_hi_nxt;
  logic [DataW-1:0] acc_lo_r, acc_lo_nxt;
  logic [DataW-1:0] dvs_r, dvs_nxt;
  logic [IterW-1:0] iter_r, iter_nxt;
  logic [CountW-1:0] bcnt_r, bcnt_nxt;
  logic             seen_r, seen_nxt;
  logic [FlagW-1:0] flags_r, flags_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DataW-1:0] out_res_r, out_res_nxt;
  logic             out_we_r, out_we_nxt;
  logic             out_trap_r, out_trap_nxt;

  logic [DataW-1:0] add_x, add_y, add_sum;
  logic             add_ci, add_co;
  logic [DataW-1:0] zimm, simm;
  logic [DataW-1:0] dtry;
  logic             pred_ok, in_acc, out_free;
  logic [DataW-1:0] ex_res;
  logic             ex_we, ex_trap, ex_sub;
  logic [FlagW-1:0] ex_fl;
  logic [DataW-1:0] ex_op1, ex_op2;
  logic [2*DataW-1:0] rot_l, rot_r;
  logic             dneg;
  logic             scan_bit;

  assign zimm = {{(DataW-ImmW){1'b0}}, imm_r};
  assign simm = {{(DataW-ImmW){imm_r[ImmW-1]}}, imm_r};
  assign {add_co, add_sum} = {1'b0, add_x} + {1'b0, add_y} + {{DataW{1'b0}}, add_ci};
  assign dtry = {acc_hi_r[DataW-2:0], acc_lo_r[DataW-1]};
  assign rot_l = {a_r, a_r} << b_r[5:0];
  assign rot_r = {a_r, a_r} >> b_r[5:0];
  assign dneg = (cmd_t'(cmd_r) == CMD_DIV) ? (a_r[DataW-1] ^ b_r[DataW-1]) : a_r[DataW-1];
  assign scan_bit = (cmd_t'(cmd_r) == CMD_CLZ) ? acc_lo_r[DataW-1] : acc_lo_r[0];

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    case (pred_t'(in_ch.pred))
      PRED_ZSET: pred_ok = flags_r[FlZ];
      PRED_ZCLR: pred_ok = !flags_r[FlZ];
      PRED_CSET: pred_ok = flags_r[FlC];
      default:   pred_ok = 1'b1;
    endcase
  end

  // shared adder operand select
  always_comb begin
    add_x  = '0;
    add_y  = '0;
    add_ci = 1'b0;
    ex_op1 = a_r;
    ex_op2 = b_r;
    ex_sub = 1'b0;
    unique case (state_r)
      S_MUL: begin
        add_x = acc_hi_r;
        add_y = acc_lo_r[0] ? a_r : '0;
      end
      S_DNA: begin
        add_x  = a_r[DataW-1] ? '0 : a_r;
        add_y  = a_r[DataW-1] ? ~a_r : '0;
        add_ci = a_r[DataW-1];
      end
      S_DNB: begin
        add_x  = b_r[DataW-1] ? '0 : b_r;
        add_y  = b_r[DataW-1] ? ~b_r : '0;
        add_ci = b_r[DataW-1];
      end
      S_DIV: begin
        add_x  = dtry;
        add_y  = ~dvs_r;
        add_ci = 1'b1;
      end
      S_EXEC: begin
        case (cmd_t'(cmd_r))
          CMD_ADDI: ex_op2 = simm;
          CMD_SUB, CMD_CMP: ex_sub = 1'b1;
          CMD_SUBI, CMD_CMPI: begin
            ex_op2 = simm;
            ex_sub = 1'b1;
          end
          CMD_NEG: begin
            ex_op1 = '0;
            ex_op2 = a_r;
            ex_sub = 1'b1;
          end
          default: ;
        endcase
        case (cmd_t'(cmd_r))
          CMD_ABS: begin
            add_x  = a_r[DataW-1] ? '0 : a_r;
            add_y  = a_r[DataW-1] ? ~a_r : '0;
            add_ci = a_r[DataW-1];
          end
          CMD_DIV, CMD_REM: begin
            add_x  = dneg ? '0 : ((cmd_t'(cmd_r) == CMD_DIV) ? acc_lo_r : acc_hi_r);
            add_y  = dneg ? ~((cmd_t'(cmd_r) == CMD_DIV) ? acc_lo_r : acc_hi_r) : '0;
            add_ci = dneg;
          end
          default: begin
            add_x  = ex_op1;
            add_y  = ex_sub ? ~ex_op2 : ex_op2;
            add_ci = ex_sub;
          end
        endcase
      end
      default: ;
    endcase
  end

  // final result and flags
  always_comb begin
    ex_res  = '0;
    ex_we   = 1'b1;
    ex_trap = 1'b0;
    ex_fl   = flags_r;
    unique case (cmd_t'(cmd_r))
      CMD_ADD, CMD_ADDI, CMD_SUB, CMD_SUBI, CMD_NEG: begin
        ex_res = add_sum;
        ex_fl  = arith_flags(add_sum, ex_op1, ex_op2, ex_sub, add_co);
      end
      CMD_MUL:    ex_res = acc_lo_r;
      CMD_MULH:   ex_res = acc_hi_r;
      CMD_DIV, CMD_REM: begin
        if (b_r == '0) begin
          ex_trap = 1'b1;
          ex_we   = 1'b0;
        end else begin
          ex_res = add_sum;
        end
      end
      CMD_ABS:    ex_res = add_sum;
      CMD_AND:    ex_res = a_r & b_r;
      CMD_ANDI:   ex_res = a_r & zimm;
      CMD_OR:     ex_res = a_r | b_r;
      CMD_ORI:    ex_res = a_r | zimm;
      CMD_XOR:    ex_res = a_r ^ b_r;
      CMD_NOT:    ex_res = ~a_r;
      CMD_SHL:    ex_res = a_r << b_r[5:0];
      CMD_SHR:    ex_res = a_r >> b_r[5:0];
      CMD_SAR:    ex_res = $unsigned($signed(a_r) >>> b_r[5:0]);
      CMD_ROL:    ex_res = rot_l[2*DataW-1:DataW];
      CMD_ROR:    ex_res = rot_r[DataW-1:0];
      CMD_CLZ, CMD_CTZ, CMD_POPC: ex_res = {{(DataW-CountW){1'b0}}, bcnt_r};
      CMD_BEXT:   ex_res = {{(DataW-1){1'b0}}, a_r[b_r[5:0]]};
      CMD_BDEP:   ex_res = {{(DataW-1){1'b0}}, a_r[0]} << b_r[5:0];
      CMD_RDFL:   ex_res = {{(DataW-FlagW){1'b0}}, flags_r};
      CMD_WRFL: begin
        ex_fl = a_r[FlagW-1:0];
        ex_we = 1'b0;
      end
      CMD_CMP, CMD_CMPI: begin
        ex_fl = arith_flags(add_sum, ex_op1, ex_op2, 1'b1, add_co);
        ex_we = 1'b0;
      end
      CMD_TST: begin
        ex_fl[FlZ] = ((a_r & b_r) == '0);
        ex_fl[FlN] = a_r[DataW-1] & b_r[DataW-1];
        ex_we      = 1'b0;
      end
      CMD_TSTI: begin
        ex_fl[FlZ] = ((a_r & zimm) == '0);
        ex_fl[FlN] = 1'b0;
        ex_we      = 1'b0;
      end
      CMD_SEQ:    ex_res = {{(DataW-1){1'b0}}, a_r == b_r};
      CMD_SNE:    ex_res = {{(DataW-1){1'b0}}, a_r != b_r};
      CMD_SLT:    ex_res = {{(DataW-1){1'b0}}, $signed(a_r) < $signed(b_r)};
      CMD_SLTU:   ex_res = {{(DataW-1){1'b0}}, a_r < b_r};
      CMD_MOV:    ex_res = a_r;
      CMD_MOVZ: begin
        ex_res = a_r;
        ex_we  = flags_r[FlZ];
      end
      CMD_MOVNZ: begin
        ex_res = a_r;
        ex_we  = !flags_r[FlZ];
      end
      CMD_MOVC: begin
        ex_res = a_r;
        ex_we  = flags_r[FlC];
      end
      CMD_MOVN: begin
        ex_res = a_r;
        ex_we  = flags_r[FlN];
      end
      CMD_SEL:    ex_res = flags_r[FlZ] ? a_r : b_r;
      CMD_ZEXT32: ex_res = {32'h0, a_r[31:0]};
      CMD_SEXT32: ex_res = {{32{a_r[31]}}, a_r[31:0]};
      CMD_SEXT16: ex_res = {{48{a_r[15]}}, a_r[15:0]};
      CMD_SEXT8:  ex_res = {{56{a_r[7]}}, a_r[7:0]};
      default:    ex_we  = 1'b0;
    endcase
    if (!pok_r) begin
      ex_we   = 1'b0;
      ex_trap = 1'b0;
      ex_fl   = flags_r;
    end
    if (!ex_we) begin
      ex_res = '0;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    imm_nxt       = imm_r;
    pok_nxt       = pok_r;
    acc_hi_nxt    = acc_hi_r;
    acc_lo_nxt    = acc_lo_r;
    dvs_nxt       = dvs_r;
    iter_nxt      = iter_r;
    bcnt_nxt      = bcnt_r;
    seen_nxt      = seen_r;
    flags_nxt     = flags_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_res_nxt   = out_res_r;
    out_we_nxt    = out_we_r;
    out_trap_nxt  = out_trap_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_ch.command;
          a_nxt      = in_ch.operand_a;
          b_nxt      = in_ch.operand_b;
          imm_nxt    = in_ch.imm6;
          pok_nxt    = pred_ok;
          iter_nxt   = '0;
          bcnt_nxt   = '0;
          seen_nxt   = 1'b0;
          acc_hi_nxt = '0;
          acc_lo_nxt = in_ch.operand_b;
          state_nxt  = S_EXEC;
          if (pred_ok) begin
            case (cmd_t'(in_ch.command))
              CMD_MUL, CMD_MULH: state_nxt = S_MUL;
              CMD_DIV, CMD_REM: begin
                if (in_ch.operand_b != '0) begin
                  state_nxt = S_DNA;
                end
              end
              CMD_CLZ, CMD_POPC: begin
                acc_lo_nxt = in_ch.operand_a;
                state_nxt  = S_BITS;
              end
              CMD_CTZ: begin
                acc_lo_nxt = in_ch.operand_a;
                state_nxt  = S_BITS;
              end
              default: ;
            endcase
          end
        end
      end
      S_MUL: begin
        acc_hi_nxt = {add_co, add_sum[DataW-1:1]};
        acc_lo_nxt = {add_sum[0], acc_lo_r[DataW-1:1]};
        iter_nxt   = iter_r + 1'b1;
        if (iter_r == '1) begin
          state_nxt = S_EXEC;
        end
      end
      S_DNA: begin
        acc_lo_nxt = add_sum;
        state_nxt  = S_DNB;
      end
      S_DNB: begin
        dvs_nxt    = add_sum;
        acc_hi_nxt = '0;
        state_nxt  = S_DIV;
      end
      S_DIV: begin
        acc_hi_nxt = add_co ? add_sum : dtry;
        acc_lo_nxt = {acc_lo_r[DataW-2:0], add_co};
        iter_nxt   = iter_r + 1'b1;
        if (iter_r == '1) begin
          state_nxt = S_EXEC;
        end
      end
      S_BITS: begin
        if (cmd_t'(cmd_r) == CMD_POPC) begin
          bcnt_nxt = bcnt_r + {{(CountW-1){1'b0}}, scan_bit};
        end else if (!seen_r && !scan_bit) begin
          bcnt_nxt = bcnt_r + 1'b1;
        end
        seen_nxt   = seen_r | scan_bit;
        acc_lo_nxt = (cmd_t'(cmd_r) == CMD_CLZ) ? (acc_lo_r << 1) : (acc_lo_r >> 1);
        iter_nxt   = iter_r + 1'b1;
        if (iter_r == '1) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = ex_res;
          out_we_nxt    = ex_we;
          out_trap_nxt  = ex_trap;
          flags_nxt     = ex_fl;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      flags_r     <= flags_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    imm_r      <= imm_nxt;
    pok_r      <= pok_nxt;
    acc_hi_r   <= acc_hi_nxt;
    acc_lo_r   <= acc_lo_nxt;
    dvs_r      <= dvs_nxt;
    iter_r     <= iter_nxt;
    bcnt_r     <= bcnt_nxt;
    seen_r     <= seen_nxt;
    out_res_r  <= out_res_nxt;
    out_we_r   <= out_we_nxt;
    out_trap_r <= out_trap_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result       = out_res_r;
  assign out_ch.write_enable = out_we_r;
  assign out_ch.arith_trap   = out_trap_r;
  assign out_ch.flags_out    = flags_r;

  `IAF_ASSERT_NXT(a_busy_after_accept, in_acc, state_r != S_IDLE)
  `IAF_ASSERT_NXT(a_exec_waits, (state_r == S_EXEC) && out_valid_r && !out_ch.ready, (state_r == S_EXEC) && $stable(flags_r))
  `IAF_ASSERT_NXT(a_div_ends, (state_r == S_DIV) && (iter_r == '1), state_r == S_EXEC)
  `IAF_ASSERT_IMP(a_trap_no_write, out_valid_r && out_trap_r, !out_we_r && (out_res_r == '0))

endmodule
